>>> src/wsts_pkg.sv
// Package: constants, payload types, states and helpers for the work-stealing scheduler.
package wsts_pkg;

    localparam int DEF_NUM_WORKERS = 8;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TASK_BITS   = 16;

    localparam logic [3:0]  RESET_WORKERS = 4'd8;
    localparam logic [23:0] RESET_INITIAL = 24'd25000;
    localparam logic [23:0] RESET_MAX     = 24'd800000;

    localparam logic [1:0] CMD_FORK = 2'd0;
    localparam logic [1:0] CMD_FIND = 2'd1;
    localparam logic [1:0] CMD_IDLE = 2'd2;

    localparam logic [1:0] REG_NUM_WORKERS = 2'd0;
    localparam logic [1:0] REG_INITIAL     = 2'd1;
    localparam logic [1:0] REG_MAX         = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  worker_id;
        logic [15:0] new_task;
        logic [30:0] rand_value;
    } wsts_in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] task_id;
        logic [2:0]  source_worker;
        logic        stolen;
        logic [23:0] delay_us;
        logic        overflow;
    } wsts_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_READ,
        ST_WAIT,
        ST_DONE
    } wsts_state_t;

endpackage

>>> src/wsts_mod.sv
// Sequential remainder of a 31-bit value by the active worker count.
module wsts_mod
    import wsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [6:0]  remainder
);
    logic [7:0]  rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  shifted;

    // Restoring remainder, two bits per cycle.
    always_comb
    begin
        logic [7:0] r;
        logic [30:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            r = {r[6:0], q[30]};
            q = {q[29:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        shifted = r;
        quo_next = q;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            // top bit already reduced, so a divisor of one starts from zero
            rem_next  = ({7'd0, dividend[30]} >= {1'b0, divisor}) ? 8'd0
                                                                  : {7'd0, dividend[30]};
        end
        else if (busy_reg)
        begin
            rem_next = shifted;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd14)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (start)
        begin
            quo_reg <= {dividend[29:0], 1'b0};
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
        end
    end

    assign done      = busy_reg && (cnt_reg == 5'd14) && !start;
    assign remainder = rem_next[6:0];
endmodule

>>> src/work_stealing_task_scheduler.sv
// Top level of the work-stealing task scheduler.
// One task at a time: a command is taken on in_valid/in_ready and yields one
// result item. Fork and idle pass through the dispatch and done states; a find
// served by the own queue adds a wait state for the slot read. A find on an
// empty own queue first reduces rand_value by the worker count in a sequential
// remainder unit, then tests one victim queue per cycle; a stalled receiver
// holds the result in the done state. Tasks live in one synchronous slot memory
// addressed by worker and slot (NUM_WORKERS*QUEUE_DEPTH entries, each rounded
// up to a power of two), with registered read data; queue pointers,
// counts and backoff state are small per-worker register files.
module work_stealing_task_scheduler
    import wsts_pkg::*;
#(
    parameter int NUM_WORKERS = DEF_NUM_WORKERS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TASK_BITS   = DEF_TASK_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wsts_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output wsts_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int WB = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CB = $clog2(QUEUE_DEPTH + 1);
    localparam int AB = WB + QB;

    logic [3:0]  num_workers_reg;
    logic [23:0] init_reg, max_reg;

    logic [QB-1:0] head_reg [NUM_WORKERS];
    logic [QB-1:0] tail_reg [NUM_WORKERS];
    logic [CB-1:0] cnt_reg  [NUM_WORKERS];
    logic [23:0]   delay_reg [NUM_WORKERS];
    logic [NUM_WORKERS-1:0] idle_reg;

    logic [TASK_BITS-1:0] slots [2**AB];
    logic [TASK_BITS-1:0] rd_data_reg;

    wsts_state_t state_reg, state_next;
    wsts_in_t    item_reg;
    wsts_out_t   res_reg;
    wsts_out_t   res_start;
    logic        out_valid_reg;
    logic [WB-1:0] vict_reg, vict_next;
    logic [6:0]    scan_reg, scan_next;
    logic          stole_reg, stole_next;

    // Effective worker count, clamped to 1..NUM_WORKERS.
    logic [6:0] n_act;
    always_comb
    begin
        if (num_workers_reg == 4'd0)
        begin
            n_act = 7'd1;
        end
        else if ({3'd0, num_workers_reg} > 7'(NUM_WORKERS))
        begin
            n_act = 7'(NUM_WORKERS);
        end
        else
        begin
            n_act = {3'd0, num_workers_reg};
        end
    end

    logic       mod_start, mod_done;
    logic [6:0] mod_rem;
    wsts_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (item_reg.rand_value),
        .divisor  (n_act),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    logic [WB-1:0] w;
    assign w = WB'(item_reg.worker_id);
    logic w_ok;
    assign w_ok = ({4'd0, item_reg.worker_id} < n_act) &&
                  (NUM_WORKERS >= 8 || item_reg.worker_id < 3'(NUM_WORKERS));

    // Memory access requests.
    logic          mem_we, mem_re;
    logic [AB-1:0] mem_addr;
    logic [TASK_BITS-1:0] mem_wdata;
    assign mem_wdata = TASK_BITS'(item_reg.new_task);

    logic [QB-1:0] tail_dec;
    assign tail_dec = (tail_reg[w] == '0) ? QB'(QUEUE_DEPTH - 1) : tail_reg[w] - 1'b1;

    logic own_ne, vict_ok;
    assign own_ne  = cnt_reg[w] != '0;
    assign vict_ok = (vict_reg != w) && (cnt_reg[vict_reg] != '0);

    logic [WB-1:0] vict_inc;
    assign vict_inc = ({1'b0, vict_reg} + 1'b1 >= n_act[WB:0]) ? '0 : vict_reg + 1'b1;

    logic take_in;
    assign take_in = in_valid && in_ready;

    // Control: next state, memory requests.
    always_comb
    begin
        state_next = state_reg;
        vict_next  = vict_reg;
        scan_next  = scan_reg;
        stole_next = stole_reg;
        mod_start  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = {w, tail_reg[w]};
        case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // Dispatch on the captured command.
                if (!w_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (item_reg.cmd == CMD_FORK)
                begin
                    if (cnt_reg[w] < CB'(QUEUE_DEPTH))
                    begin
                        mem_we = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (item_reg.cmd == CMD_FIND)
                begin
                    if (own_ne)
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = {w, tail_dec};
                        stole_next = 1'b0;
                        vict_next  = w;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (mod_done)
                begin
                    vict_next  = mod_rem[WB-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (scan_reg >= n_act)
                begin
                    state_next = ST_DONE;
                end
                else if (vict_ok)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = {vict_reg, head_reg[vict_reg]};
                    stole_next = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    vict_next = vict_inc;
                    scan_next = scan_reg + 7'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slots[mem_addr];
        end
    end

    logic [24:0] dbl;
    assign dbl = {delay_reg[w], 1'b0};

    logic found_now;
    assign found_now = (state_reg == ST_WAIT);

    // Result fields known at dispatch.
    always_comb
    begin
        res_start = '0;
        if (w_ok && item_reg.cmd == CMD_FORK && cnt_reg[w] >= CB'(QUEUE_DEPTH))
        begin
            res_start.overflow = 1'b1;
        end
        if (w_ok && item_reg.cmd == CMD_IDLE)
        begin
            res_start.delay_us = delay_reg[w];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_workers_reg <= RESET_WORKERS;
            init_reg        <= RESET_INITIAL;
            max_reg         <= RESET_MAX;
            out_valid_reg   <= 1'b0;
            idle_reg        <= '0;
            vict_reg        <= '0;
            scan_reg        <= '0;
            stole_reg       <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                delay_reg[i] <= RESET_INITIAL;
            end
        end
        else
        begin
            state_reg <= state_next;
            vict_reg  <= vict_next;
            scan_reg  <= scan_next;
            stole_reg <= stole_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_WORKERS: num_workers_reg <= cfg_data[3:0];
                    REG_INITIAL:     init_reg <= cfg_data;
                    REG_MAX:         max_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                tail_reg[w] <= (32'(tail_reg[w]) + 1 >= QUEUE_DEPTH) ? '0 : tail_reg[w] + 1'b1;
                cnt_reg[w]  <= cnt_reg[w] + 1'b1;
            end
            if (mem_re && !stole_next)
            begin
                tail_reg[w] <= tail_dec;
                cnt_reg[w]  <= cnt_reg[w] - 1'b1;
            end
            if (mem_re && stole_next)
            begin
                head_reg[vict_reg] <= (32'(head_reg[vict_reg]) + 1 >= QUEUE_DEPTH) ?
                                      '0 : head_reg[vict_reg] + 1'b1;
                cnt_reg[vict_reg]  <= cnt_reg[vict_reg] - 1'b1;
            end
            if (found_now && idle_reg[w])
            begin
                idle_reg[w]  <= 1'b0;
                delay_reg[w] <= init_reg;
            end
            if (state_reg == ST_MOD && w_ok && item_reg.cmd == CMD_IDLE)
            begin
                idle_reg[w] <= 1'b1;
                if (delay_reg[w] < max_reg)
                begin
                    delay_reg[w] <= (dbl > {1'b0, max_reg}) ? max_reg : dbl[23:0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_MOD)
        begin
            res_reg <= res_start;
        end
        if (found_now)
        begin
            res_reg.found         <= 1'b1;
            res_reg.task_id       <= 16'(rd_data_reg);
            res_reg.source_worker <= 3'(vict_reg);
            res_reg.stolen        <= stole_reg;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_data <= res_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
endmodule

>>> src/wsts_checker.sv
// Port-level checker for the work-stealing scheduler, bound to the top level.
module wsts_checker
    import wsts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input wsts_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.task_id == '0 && !out_data.stolen)
        else $error("task fields set without a found task");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.found && out_data.overflow) &&
                      !(out_data.found && out_data.delay_us != '0))
        else $error("result mixes fields of different commands");
endmodule

bind work_stealing_task_scheduler wsts_checker u_wsts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

>>> bench/tb_top.sv
// Testbench for the work-stealing task scheduler: queue and backoff predictor with result checks.
module tb_top
    import wsts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORKERS = 8;
    localparam int DEPTH   = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int EXP_SLOTS = 4096;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    wsts_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    wsts_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    work_stealing_task_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted scheduler state
    logic [15:0] slots [WORKERS][DEPTH];
    int          head [WORKERS];
    int          tail [WORKERS];
    int          fill [WORKERS];
    logic [23:0] backoff [WORKERS];
    logic        idle_flag [WORKERS];
    logic [3:0]  cur_workers;
    logic [23:0] cur_initial;
    logic [23:0] cur_max;

    // expected results, oldest at exp_rd
    wsts_out_t   exp_results [EXP_SLOTS];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          cycles;
    bit          sink_hold;
    bit          use_noise;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int live_workers();
        if (cur_workers == 0)
            return 1;
        if (cur_workers > WORKERS)
            return WORKERS;
        return int'(cur_workers);
    endfunction

    function automatic wsts_out_t schedule_step(wsts_in_t it);
        wsts_out_t r;
        int n;
        int w;
        int v;
        int src;
        bit got;
        bit stole;
        logic [15:0] t;
        logic [24:0] dbl;
        r = '0;
        n = live_workers();
        w = int'(it.worker_id);
        got = 0;
        stole = 0;
        src = 0;
        t = '0;
        if (w >= n)
            return r;
        case (it.cmd)
            CMD_FORK:
            begin
                if (fill[w] >= DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    slots[w][tail[w]] = it.new_task;
                    tail[w] = (tail[w] + 1) % DEPTH;
                    fill[w]++;
                end
            end
            CMD_FIND:
            begin
                if (fill[w] > 0)
                begin
                    tail[w] = (tail[w] + DEPTH - 1) % DEPTH;
                    fill[w]--;
                    t = slots[w][tail[w]];
                    src = w;
                    got = 1;
                end
                else
                begin
                    v = int'(it.rand_value % n);
                    for (int c = 0; c < n; c++)
                    begin
                        if (v != w && fill[v] > 0)
                        begin
                            t = slots[v][head[v]];
                            head[v] = (head[v] + 1) % DEPTH;
                            fill[v]--;
                            src = v;
                            stole = 1;
                            got = 1;
                            break;
                        end
                        v = (v + 1 >= n) ? 0 : v + 1;
                    end
                end
                if (got)
                begin
                    if (idle_flag[w])
                    begin
                        idle_flag[w] = 1'b0;
                        backoff[w] = cur_initial;
                    end
                    r.found = 1'b1;
                    r.task_id = t;
                    r.source_worker = src[2:0];
                    r.stolen = stole;
                end
            end
            CMD_IDLE:
            begin
                idle_flag[w] = 1'b1;
                r.delay_us = backoff[w];
                if (backoff[w] < cur_max)
                begin
                    dbl = {backoff[w], 1'b0};
                    if (dbl > {1'b0, cur_max})
                        dbl = {1'b0, cur_max};
                    backoff[w] = dbl[23:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input int worker, input logic [15:0] task_val,
                            input logic [30:0] rnd, input bit no_gap = 0);
        wsts_in_t it;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (!no_gap && $urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(posedge clk);
        it.cmd = cmd;
        it.worker_id = worker[2:0];
        it.new_task = task_val;
        it.rand_value = rnd;
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        exp_results[exp_wr % EXP_SLOTS] = schedule_step(it);
        exp_wr++;
        in_valid <= 1'b0;
        // block stays busy after taking an item
        @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        wsts_out_t want;
        if (out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result %h", out_data);
                errors++;
            end
            else
            begin
                want = exp_results[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (out_data.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, out_data.found);
                    errors++;
                end
                if (out_data.task_id !== want.task_id)
                begin
                    $error("task_id exp %0d got %0d", want.task_id, out_data.task_id);
                    errors++;
                end
                if (out_data.source_worker !== want.source_worker)
                begin
                    $error("source_worker exp %0d got %0d", want.source_worker,
                           out_data.source_worker);
                    errors++;
                end
                if (out_data.stolen !== want.stolen)
                begin
                    $error("stolen exp %0d got %0d", want.stolen, out_data.stolen);
                    errors++;
                end
                if (out_data.delay_us !== want.delay_us)
                begin
                    $error("delay_us exp %0d got %0d", want.delay_us, out_data.delay_us);
                    errors++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $error("overflow exp %0d got %0d", want.overflow, out_data.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_left;
        out_ready = 1'b0;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold)
                out_ready <= 1'b0;
            else if (wait_left > 0)
            begin
                wait_left--;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                wait_left = use_noise ? $urandom_range(0, 7) : 0;
                out_ready <= (wait_left == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic drain();
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NUM_WORKERS: cur_workers = val[3:0];
            REG_INITIAL:     cur_initial = val;
            REG_MAX:         cur_max = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_random(input int count, input int fork_weight);
        int pick;
        int w;
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < fork_weight)
                cmd = CMD_FORK;
            else if (pick < 85)
                cmd = CMD_FIND;
            else if (pick < 97)
                cmd = CMD_IDLE;
            else
                cmd = 2'd3;
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7)
                                             : $urandom_range(0, live_workers() - 1);
            send_cmd(cmd, w, 16'($urandom), 31'($urandom));
        end
    endtask

    task automatic test_directed();
        // fork extremes, own pop, steal, idle doubling, bad cmd, unused worker
        send_cmd(CMD_FORK, 0, 16'h0000, '0);
        send_cmd(CMD_FORK, 0, 16'hFFFF, '0);
        send_cmd(CMD_FORK, 7, 16'hA5A5, '0);
        send_cmd(CMD_FIND, 0, 16'hFFFF, 31'h7FFF_FFFF);
        send_cmd(CMD_FIND, 3, '0, 31'h7FFF_FFFF);
        send_cmd(CMD_FIND, 3, '0, 31'd0);
        send_cmd(CMD_FIND, 3, '0, 31'd5);
        for (int i = 0; i < 7; i++)
            send_cmd(CMD_IDLE, 2, '0, '0);
        send_cmd(CMD_FORK, 1, 16'h1234, '0);
        send_cmd(CMD_FIND, 2, '0, 31'h5555_5555);
        send_cmd(CMD_IDLE, 2, '0, '0);
        send_cmd(2'd3, 1, 16'hFFFF, 31'h7FFF_FFFF);
        send_cmd(CMD_FIND, 1, '0, '0);
        drain();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 3; i++)
            send_cmd(CMD_FORK, 4, 16'(i * 997), '0, 1);
        send_random(60, 20);
        drain();
    endtask

    task automatic test_configs();
        // worker count extremes including out-of-range codes
        write_reg(REG_NUM_WORKERS, 24'd1);
        write_reg(REG_INITIAL, 24'd1);
        write_reg(REG_MAX, 24'hFFFFFF);
        send_random(120, 45);
        for (int i = 0; i < 26; i++)
            send_cmd(CMD_IDLE, 0, '0, '0);
        drain();
        write_reg(REG_NUM_WORKERS, 24'd0);
        write_reg(REG_INITIAL, 24'd0);
        write_reg(REG_MAX, 24'd1);
        send_random(80, 40);
        drain();
        write_reg(REG_NUM_WORKERS, 24'd15);
        write_reg(REG_INITIAL, 24'hFFFFFF);
        write_reg(REG_MAX, 24'd100);
        send_random(120, 40);
        drain();
        write_reg(REG_NUM_WORKERS, 24'd3);
        write_reg(REG_INITIAL, 24'd7);
        write_reg(REG_MAX, 24'd1000);
        send_random(200, 40);
        drain();
        write_reg(REG_NUM_WORKERS, 24'd8);
        write_reg(REG_INITIAL, 24'd25000);
        write_reg(REG_MAX, 24'd800000);
    endtask

    task automatic test_backpressure();
        sink_hold = 1;
        fork
            send_random(30, 50);
            begin
                repeat (300) @(posedge clk);
                sink_hold = 0;
            end
        join
        drain();
    endtask

    task automatic test_random();
        use_noise = 0;
        send_random(100, 40);
        use_noise = 1;
        send_random(350, 40);
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        sink_hold = 0;
        use_noise = 1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_NUM_WORKERS;
        cfg_data = '0;
        cur_workers = RESET_WORKERS;
        cur_initial = RESET_INITIAL;
        cur_max = RESET_MAX;
        for (int w = 0; w < WORKERS; w++)
        begin
            head[w] = 0;
            tail[w] = 0;
            fill[w] = 0;
            backoff[w] = RESET_INITIAL;
            idle_flag[w] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_configs();
        test_random();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
